/* design/bsort_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter package
// Shared types and constants: micro-operation codes, jump conditions,
// step addresses of the control program and the control and status words.
// ----------------------------------------------------------------------------
package bsort_pkg;

   // Element width of the sort data.
   localparam int DATA_W = 32;

   // Width of the micro-program step counter.
   localparam int STEP_W = 3;

   // Micro-operations that one control word can issue to the datapath.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_NET_INIT,
      OP_CX_READ,
      OP_CX_WR_A,
      OP_CX_WR_B,
      OP_EMIT_RD,
      OP_EMIT_WR
   } op_type;

   // Jump conditions; a true condition loads the jump target.
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_LOAD_WAIT,
      C_NET_MORE,
      C_OUT_BUSY,
      C_EMIT_MORE
   } cond_sel_type;

   // Step addresses of the control program.
   localparam logic [STEP_W-1:0] STEP_LOAD     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_NET_INIT = 3'd1;
   localparam logic [STEP_W-1:0] STEP_CX_READ  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_CX_WR_A  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_CX_WR_B  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT_RD  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT_WR  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_RESTART  = 3'd7;

   // One word of the control store.
   typedef struct packed {
      op_type              op;
      cond_sel_type        cond;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   // Condition flags returned by the datapath to the sequencer.
   typedef struct packed {
      logic load_wait;
      logic net_more;
      logic out_busy;
      logic emit_more;
   } status_type;

endpackage

/* design/bsort_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter control store
// Read-only micro-program: one control word per step address.
// ----------------------------------------------------------------------------
module bsort_rom (
   input  logic [bsort_pkg::STEP_W-1:0] step,
   output bsort_pkg::ctrl_word_type     ctrl
);

   // The program: load a block, run the network, emit the block.
   always_comb begin
      unique case (step)
         bsort_pkg::STEP_LOAD: begin
            ctrl = '{bsort_pkg::OP_LOAD, bsort_pkg::C_LOAD_WAIT, bsort_pkg::STEP_LOAD};
         end
         bsort_pkg::STEP_NET_INIT: begin
            ctrl = '{bsort_pkg::OP_NET_INIT, bsort_pkg::C_NEVER, bsort_pkg::STEP_LOAD};
         end
         bsort_pkg::STEP_CX_READ: begin
            ctrl = '{bsort_pkg::OP_CX_READ, bsort_pkg::C_NEVER, bsort_pkg::STEP_LOAD};
         end
         bsort_pkg::STEP_CX_WR_A: begin
            ctrl = '{bsort_pkg::OP_CX_WR_A, bsort_pkg::C_NEVER, bsort_pkg::STEP_LOAD};
         end
         bsort_pkg::STEP_CX_WR_B: begin
            ctrl = '{bsort_pkg::OP_CX_WR_B, bsort_pkg::C_NET_MORE,
                     bsort_pkg::STEP_CX_READ};
         end
         bsort_pkg::STEP_EMIT_RD: begin
            ctrl = '{bsort_pkg::OP_EMIT_RD, bsort_pkg::C_OUT_BUSY,
                     bsort_pkg::STEP_EMIT_RD};
         end
         bsort_pkg::STEP_EMIT_WR: begin
            ctrl = '{bsort_pkg::OP_EMIT_WR, bsort_pkg::C_EMIT_MORE,
                     bsort_pkg::STEP_EMIT_RD};
         end
         bsort_pkg::STEP_RESTART: begin
            ctrl = '{bsort_pkg::OP_NOP, bsort_pkg::C_ALWAYS, bsort_pkg::STEP_LOAD};
         end
         default: begin
            ctrl = '{bsort_pkg::OP_NOP, bsort_pkg::C_ALWAYS, bsort_pkg::STEP_LOAD};
         end
      endcase
   end

endmodule

/* design/bsort_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter sequencer
// Step counter with conditional jumps; fetches the control word of the
// current step from the control store.
// ----------------------------------------------------------------------------
module bsort_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  bsort_pkg::status_type     status,
   output bsort_pkg::ctrl_word_type  ctrl
);

   logic [bsort_pkg::STEP_W-1:0] step_ff;
   logic [bsort_pkg::STEP_W-1:0] step_in;
   logic                         jump;

   bsort_rom u_rom (
      .step (step_ff),
      .ctrl (ctrl)
   );

   // Select the jump condition named by the control word.
   always_comb begin
      unique case (ctrl.cond)
         bsort_pkg::C_NEVER:     jump = 1'b0;
         bsort_pkg::C_ALWAYS:    jump = 1'b1;
         bsort_pkg::C_LOAD_WAIT: jump = status.load_wait;
         bsort_pkg::C_NET_MORE:  jump = status.net_more;
         bsort_pkg::C_OUT_BUSY:  jump = status.out_busy;
         bsort_pkg::C_EMIT_MORE: jump = status.emit_more;
         default:                jump = 1'b0;
      endcase
      step_in = jump ? ctrl.target : step_ff + bsort_pkg::STEP_W'(1);
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bsort_pkg::STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* design/bsort_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter element store
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module bsort_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [bsort_pkg::DATA_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_a_addr,
   input  logic [AW-1:0]                 rd_b_addr,
   output logic [bsort_pkg::DATA_W-1:0]  rd_a_data,
   output logic [bsort_pkg::DATA_W-1:0]  rd_b_data
);

   logic [bsort_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [bsort_pkg::DATA_W-1:0] rd_a_ff;
   logic [bsort_pkg::DATA_W-1:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports; data holds between read enables.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* design/bitonic_sorter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter top level
// Collects SORT_LENGTH signed values, sorts them with a bitonic network
// run by a micro-programmed sequencer, and streams them out in order.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one signed 32-bit value per transfer. While a
//   block is loading, a value is taken every cycle that req_valid is high.
//   The transfer that completes the block starts the sort; req_stall then
//   stays high until the whole sorted block has been handed to the rsp
//   output register.
//   The rsp channel delivers the block in ascending order, one value per
//   transfer, with rsp_is_last set on the final value.
//   For a block of N = SORT_LENGTH values, the network is an init step and
//   log2(N) * (log2(N)+1) / 2 passes of N/2 compare-exchanges on one
//   comparator, with three element store accesses per compare-exchange;
//   emission reads each value from the store, then loads it into the rsp
//   output register.
//   A stalled rsp transfer holds its value; emission waits on it. The next
//   block can start loading while the last value still waits on the output.
//   Reset returns the sequencer to loading with an empty block.
// ----------------------------------------------------------------------------
module bitonic_sorter_top #(
   parameter int SORT_LENGTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_sorted_value,
   output logic                 rsp_is_last
);

   localparam int IDXW = $clog2(SORT_LENGTH);
   localparam logic [IDXW-1:0] LAST_IDX   = IDXW'(SORT_LENGTH - 1);
   localparam logic [IDXW-1:0] PAIR_LAST  = IDXW'(SORT_LENGTH / 2 - 1);
   localparam logic [IDXW:0]   STAGE_LAST = (IDXW + 1)'(SORT_LENGTH);

   bsort_pkg::ctrl_word_type ctrl;
   bsort_pkg::status_type    status;

   logic [IDXW-1:0]  cnt_ff,   cnt_in;
   logic [IDXW:0]    stage_ff, stage_in;
   logic [IDXW-1:0]  dist_ff,  dist_in;
   logic [IDXW-1:0]  pair_ff,  pair_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff;
   logic             rsp_last_ff;

   logic             req_accept;
   logic             out_free;
   logic [IDXW-1:0]  dist_mask;
   logic [IDXW-1:0]  ka, kb;
   logic             ascending;
   logic             mem_wr_en;
   logic [IDXW-1:0]  mem_wr_addr;
   logic [31:0]      mem_wr_data;
   logic             mem_rd_en;
   logic [IDXW-1:0]  mem_rd_a_addr;
   logic [31:0]      rd_a_data, rd_b_data;
   logic [31:0]      low_val, high_val;

   bsort_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   bsort_mem #(
      .DEPTH (SORT_LENGTH),
      .AW    (IDXW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_a_addr (mem_rd_a_addr),
      .rd_b_addr (kb),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Handshakes.
   assign req_stall  = (ctrl.op != bsort_pkg::OP_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Pair addresses: insert a zero at the distance bit of the pair index.
   always_comb begin
      dist_mask = dist_ff - IDXW'(1);
      ka        = ((pair_ff & ~dist_mask) << 1) | (pair_ff & dist_mask);
      kb        = ka | dist_ff;
      ascending = (({1'b0, ka} & stage_ff) == '0);
   end

   // Comparator on the registered pair.
   always_comb begin
      if ($signed(rd_b_data) < $signed(rd_a_data)) begin
         low_val  = rd_b_data;
         high_val = rd_a_data;
      end else begin
         low_val  = rd_a_data;
         high_val = rd_b_data;
      end
   end

   // Element store port control.
   always_comb begin
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cnt_ff;
      mem_wr_data   = req_value;
      mem_rd_en     = 1'b0;
      mem_rd_a_addr = ka;
      unique case (ctrl.op)
         bsort_pkg::OP_LOAD: begin
            mem_wr_en = req_accept;
         end
         bsort_pkg::OP_CX_READ: begin
            mem_rd_en = 1'b1;
         end
         bsort_pkg::OP_CX_WR_A: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ka;
            mem_wr_data = ascending ? low_val : high_val;
         end
         bsort_pkg::OP_CX_WR_B: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = kb;
            mem_wr_data = ascending ? high_val : low_val;
         end
         bsort_pkg::OP_EMIT_RD: begin
            mem_rd_en     = out_free;
            mem_rd_a_addr = cnt_ff;
         end
         default: begin
         end
      endcase
   end

   // Counters of the load, network and emit loops.
   always_comb begin
      cnt_in   = cnt_ff;
      stage_in = stage_ff;
      dist_in  = dist_ff;
      pair_in  = pair_ff;
      if ((ctrl.op == bsort_pkg::OP_LOAD && req_accept) ||
          ctrl.op == bsort_pkg::OP_EMIT_WR) begin
         cnt_in = (cnt_ff == LAST_IDX) ? '0 : cnt_ff + IDXW'(1);
      end
      if (ctrl.op == bsort_pkg::OP_NET_INIT) begin
         stage_in = (IDXW + 1)'(2);
         dist_in  = IDXW'(1);
         pair_in  = '0;
      end else if (ctrl.op == bsort_pkg::OP_CX_WR_B) begin
         if (pair_ff == PAIR_LAST) begin
            pair_in = '0;
            if (dist_ff == IDXW'(1)) begin
               stage_in = stage_ff << 1;
               dist_in  = stage_ff[IDXW-1:0];
            end else begin
               dist_in = dist_ff >> 1;
            end
         end else begin
            pair_in = pair_ff + IDXW'(1);
         end
      end
   end

   // Flags for the sequencer.
   always_comb begin
      status.load_wait = !(req_accept && cnt_ff == LAST_IDX);
      status.net_more  = !(pair_ff == PAIR_LAST && dist_ff == IDXW'(1) &&
                           stage_ff == STAGE_LAST);
      status.out_busy  = !out_free;
      status.emit_more = (cnt_ff != LAST_IDX);
   end

   // Output register valid.
   always_comb begin
      if (ctrl.op == bsort_pkg::OP_EMIT_WR) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         stage_ff     <= (IDXW + 1)'(2);
         dist_ff      <= IDXW'(1);
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         stage_ff     <= stage_in;
         dist_ff      <= dist_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (ctrl.op == bsort_pkg::OP_EMIT_WR) begin
         rsp_value_ff <= $signed(rd_a_data);
         rsp_last_ff  <= (cnt_ff == LAST_IDX);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_is_last      = rsp_last_ff;

   // The output register is only loaded when it is empty.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == bsort_pkg::OP_EMIT_WR) |-> !rsp_valid_ff)
      else $error("output register overwritten while holding a value");

   // At the restart step the last value sits in the output register and the
   // block counter is back at zero.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == bsort_pkg::OP_NOP) |->
         (rsp_valid_ff && rsp_last_ff && cnt_ff == '0))
      else $error("block counter not cleared after last value");

   // Compare-exchange partners differ exactly in the distance bit.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == bsort_pkg::OP_CX_READ) |->
         ((ka & dist_ff) == '0 && kb == (ka | dist_ff) && $onehot(dist_ff)))
      else $error("bad compare-exchange pair");

   // The merge distance stays below the stage size during the network.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == bsort_pkg::OP_CX_WR_A || ctrl.op == bsort_pkg::OP_CX_WR_B) |->
         ($onehot(stage_ff) && ({1'b0, dist_ff} < stage_ff)))
      else $error("stage and distance out of step");

endmodule
